/* rtl/lbps_pkg.sv */
`timescale 1ns / 1ps

package lbps_pkg;

  // Request kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_PLAY   = 2'd1,
    KIND_START  = 2'd2,
    KIND_CANCEL = 2'd3
  } kind_t;

  // Blink patterns.
  typedef enum logic [1:0] {
    PAT_SINGLE = 2'd0,
    PAT_DOUBLE = 2'd1,
    PAT_TRIPLE = 2'd2,
    PAT_BURST  = 2'd3
  } pat_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ON_MS       = 2'd0;
  localparam logic [1:0] CFG_OFF_MS      = 2'd1;
  localparam logic [1:0] CFG_ACTIVE_HIGH = 2'd2;

  localparam logic [15:0] ON_MS_RESET  = 16'd100;
  localparam logic [15:0] OFF_MS_RESET = 16'd100;

  // Pulse index width; a burst has at most fifteen pulses.
  localparam int PULSE_W = 4;

  // floor(y / 5) for y below 2^18 equals (y * RECIP5) >> 18.
  localparam logic [17:0] RECIP5 = 18'd52429;

  typedef struct packed {
    kind_t       kind;
    pat_t        pattern;
    logic [31:0] repeat_period_ms;
    logic [31:0] repeat_total_ms;
  } in_item_t;

  typedef struct packed {
    logic       led_pin;
    logic       playing;
    logic       dropped;
    logic       repeating;
    logic [3:0] queued;
  } out_item_t;

  // Classified request handed from the front end to the sequencer.
  typedef struct packed {
    kind_t       kind;
    pat_t        pattern;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [31:0] period_ms;
    logic [31:0] total_ms;
  } cmd_t;

  // One queued pattern with the times captured at enqueue.
  typedef struct packed {
    pat_t        pat;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
  } entry_t;

endpackage

/* rtl/lbps_fifo.sv */
`timescale 1ns / 1ps

module lbps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/lbps_front.sv */
`timescale 1ns / 1ps

module lbps_front import lbps_pkg::*; #(
  parameter int MIN_PERIOD_MS = 50
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  in_item_t    in_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        cmd_full,
  output logic        cmd_push,
  output cmd_t        cmd,
  output logic        active_high
);

  logic [15:0] on_ms_r, off_ms_r;
  logic        active_high_r;
  logic [15:0] on_scaled, off_scaled;
  logic        use_scaled;

  // floor(3x/5) by a reciprocal multiply.
  function automatic logic [15:0] scale_3_5(input logic [15:0] x);
    logic [17:0] y;
    logic [35:0] p;
    y = {1'b0, x, 1'b0} + {2'b00, x};
    p = 36'(y) * 36'(RECIP5);
    return p[33:18];
  endfunction

  assign cfg_ready   = 1'b1;
  assign active_high = active_high_r;
  assign in_full     = cmd_full;
  assign cmd_push    = in_push && !cmd_full;

  always_comb begin
    on_scaled  = scale_3_5(on_ms_r);
    off_scaled = scale_3_5(off_ms_r);
    use_scaled = (in_data.kind == KIND_PLAY) && (in_data.pattern == PAT_BURST);
    cmd.kind      = in_data.kind;
    cmd.pattern   = in_data.pattern;
    cmd.on_ms     = use_scaled ? on_scaled : on_ms_r;
    cmd.off_ms    = use_scaled ? off_scaled : off_ms_r;
    cmd.period_ms = (in_data.repeat_period_ms < 32'(MIN_PERIOD_MS)) ?
                    32'(MIN_PERIOD_MS) : in_data.repeat_period_ms;
    cmd.total_ms  = in_data.repeat_total_ms;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_ms_r       <= ON_MS_RESET;
      off_ms_r      <= OFF_MS_RESET;
      active_high_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ON_MS:       on_ms_r       <= cfg_data;
        CFG_OFF_MS:      off_ms_r      <= cfg_data;
        CFG_ACTIVE_HIGH: active_high_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/lbps_back.sv */
`timescale 1ns / 1ps

module lbps_back import lbps_pkg::*; #(
  parameter int QUEUE_DEPTH   = 8,
  parameter int BURST_PULSES  = 6,
  parameter int MIN_PERIOD_MS = 50
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      go,
  input  cmd_t      cmd,
  input  logic      active_high,
  output out_item_t res
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic               active;
    logic               in_on;
    logic [PULSE_W-1:0] idx;
    logic [15:0]        rem;
  } play_t;

  entry_t             fifo_mem_r [QUEUE_DEPTH];
  logic [PW-1:0]      head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]      count_r, count_nxt;

  logic               active_r, in_on_r;
  logic [PULSE_W-1:0] pidx_r;
  logic [15:0]        rem_r;
  pat_t               apat_r, apat_nxt;
  logic [15:0]        cur_on_r, cur_on_nxt, cur_off_r, cur_off_nxt;

  logic               rpt_on_r, rpt_on_nxt, rpt_triple_r, rpt_triple_nxt;
  logic [31:0]        per_len_r, per_len_nxt, per_cnt_r, per_cnt_nxt;
  logic [31:0]        elapsed_r, elapsed_nxt, limit_r, limit_nxt;

  logic [31:0]        cnt1, el1;
  logic [15:0]        rem_dec;
  play_t              ply;
  entry_t             push_ent, head_ent, load_ent;
  logic               push_ok, load, dropped, lit;

  function automatic logic [PULSE_W-1:0] pulses_of(input pat_t p);
    case (p)
      PAT_SINGLE: return PULSE_W'(1);
      PAT_DOUBLE: return PULSE_W'(2);
      PAT_TRIPLE: return PULSE_W'(3);
      default:    return PULSE_W'(BURST_PULSES);
    endcase
  endfunction

  // Skips every zero-length phase after the phase at idx has run out, in closed form.
  function automatic play_t settle(input pat_t p, input logic [15:0] on,
                                   input logic [15:0] off, input logic in_on,
                                   input logic [PULSE_W-1:0] idx);
    logic [PULSE_W-1:0] n, j;
    logic [15:0]        last, gap;
    play_t              r;
    n    = pulses_of(p);
    last = (p == PAT_SINGLE) ? off : {off[14:0], 1'b0};
    j    = idx + 1'b1;
    gap  = (idx == n - 1'b1) ? last : off;
    r    = '{active: 1'b1, in_on: 1'b0, idx: idx, rem: 16'd0};
    if (in_on && (gap != 16'd0)) begin
      r.rem = gap;
    end else if (j >= n) begin
      r = '{active: 1'b0, in_on: 1'b0, idx: '0, rem: 16'd0};
    end else if (on != 16'd0) begin
      r = '{active: 1'b1, in_on: 1'b1, idx: j, rem: on};
    end else if (j != n - 1'b1) begin
      if (off != 16'd0) begin
        r = '{active: 1'b1, in_on: 1'b0, idx: j, rem: off};
      end else begin
        r = '{active: 1'b0, in_on: 1'b0, idx: '0, rem: 16'd0};
      end
    end else if (last != 16'd0) begin
      r = '{active: 1'b1, in_on: 1'b0, idx: j, rem: last};
    end else begin
      r = '{active: 1'b0, in_on: 1'b0, idx: '0, rem: 16'd0};
    end
    return r;
  endfunction

  always_comb begin
    push_ok        = 1'b0;
    load           = 1'b0;
    dropped        = 1'b0;
    push_ent       = '{pat: cmd.pattern, on_ms: cmd.on_ms, off_ms: cmd.off_ms};
    head_ent       = fifo_mem_r[head_r];
    load_ent       = head_ent;
    rpt_on_nxt     = rpt_on_r;
    rpt_triple_nxt = rpt_triple_r;
    per_len_nxt    = per_len_r;
    per_cnt_nxt    = per_cnt_r;
    elapsed_nxt    = elapsed_r;
    limit_nxt      = limit_r;
    apat_nxt       = apat_r;
    cur_on_nxt     = cur_on_r;
    cur_off_nxt    = cur_off_r;
    cnt1           = per_cnt_r + 32'd1;
    el1            = (&elapsed_r) ? elapsed_r : elapsed_r + 32'd1;
    rem_dec        = rem_r - 16'(rem_r != 16'd0);
    ply            = '{active: active_r, in_on: in_on_r, idx: pidx_r, rem: rem_r};

    case (cmd.kind)
      KIND_PLAY: begin
        if (count_r < CW'(QUEUE_DEPTH)) begin
          push_ok = 1'b1;
        end else begin
          dropped = 1'b1;
        end
      end
      KIND_START: begin
        if ((cmd.pattern == PAT_DOUBLE) || (cmd.pattern == PAT_TRIPLE)) begin
          rpt_on_nxt     = 1'b1;
          rpt_triple_nxt = (cmd.pattern == PAT_TRIPLE);
          per_len_nxt    = cmd.period_ms;
          limit_nxt      = cmd.total_ms;
          per_cnt_nxt    = 32'd0;
          elapsed_nxt    = 32'd0;
        end
      end
      KIND_CANCEL: begin
        rpt_on_nxt     = 1'b0;
        rpt_triple_nxt = 1'b0;
        per_cnt_nxt    = 32'd0;
        elapsed_nxt    = 32'd0;
        limit_nxt      = 32'd0;
      end
      default: begin
        // Repeat timer first: it may post a pattern on this tick.
        push_ent.pat = rpt_triple_r ? PAT_TRIPLE : PAT_DOUBLE;
        if (rpt_on_r) begin
          elapsed_nxt = el1;
          per_cnt_nxt = cnt1;
          if (cnt1 >= per_len_r) begin
            per_cnt_nxt = 32'd0;
            if ((limit_r != 32'd0) && (el1 >= limit_r)) begin
              rpt_on_nxt     = 1'b0;
              rpt_triple_nxt = 1'b0;
              elapsed_nxt    = 32'd0;
              limit_nxt      = 32'd0;
            end else if (count_r < CW'(QUEUE_DEPTH)) begin
              push_ok = 1'b1;
            end else begin
              dropped = 1'b1;
            end
          end
        end
        // Then playback counts down one millisecond.
        if (active_r) begin
          if (rem_dec == 16'd0) begin
            ply = settle(apat_r, cur_on_r, cur_off_r, in_on_r, pidx_r);
          end else begin
            ply.rem = rem_dec;
          end
        end
        // An idle player takes the oldest pattern, which may be the one just posted.
        if (!ply.active && ((count_r != '0) || push_ok)) begin
          load        = 1'b1;
          load_ent    = (count_r == '0) ? push_ent : head_ent;
          apat_nxt    = load_ent.pat;
          cur_on_nxt  = load_ent.on_ms;
          cur_off_nxt = load_ent.off_ms;
          if (load_ent.on_ms != 16'd0) begin
            ply = '{active: 1'b1, in_on: 1'b1, idx: '0, rem: load_ent.on_ms};
          end else begin
            ply = settle(load_ent.pat, load_ent.on_ms, load_ent.off_ms, 1'b1, '0);
          end
        end
      end
    endcase

    count_nxt = count_r + CW'(push_ok) - CW'(load);
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    if (load) begin
      head_nxt = (head_r == PW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (push_ok) begin
      tail_nxt = (tail_r == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end

    lit           = ply.active && ply.in_on;
    res.led_pin   = active_high ? lit : !lit;
    res.playing   = ply.active;
    res.dropped   = dropped;
    res.repeating = rpt_on_nxt;
    res.queued    = 4'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      active_r     <= 1'b0;
      in_on_r      <= 1'b0;
      pidx_r       <= '0;
      rem_r        <= 16'd0;
      rpt_on_r     <= 1'b0;
      rpt_triple_r <= 1'b0;
      per_len_r    <= 32'(MIN_PERIOD_MS);
      per_cnt_r    <= 32'd0;
      elapsed_r    <= 32'd0;
      limit_r      <= 32'd0;
    end else if (go) begin
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      active_r     <= ply.active;
      in_on_r      <= ply.in_on;
      pidx_r       <= ply.idx;
      rem_r        <= ply.rem;
      rpt_on_r     <= rpt_on_nxt;
      rpt_triple_r <= rpt_triple_nxt;
      per_len_r    <= per_len_nxt;
      per_cnt_r    <= per_cnt_nxt;
      elapsed_r    <= elapsed_nxt;
      limit_r      <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      apat_r    <= apat_nxt;
      cur_on_r  <= cur_on_nxt;
      cur_off_r <= cur_off_nxt;
      if (push_ok) begin
        fifo_mem_r[tail_r] <= push_ent;
      end
    end
  end

  // A playing pattern always sits in a phase with time left on it.
  a_active_rem: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (rem_r != 16'd0))
    else $error("active pattern with no time left in its phase");

  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (pidx_r < pulses_of(apat_r)))
    else $error("pulse index beyond the pattern length");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("pattern queue count beyond its depth");

  a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
    rpt_on_r |-> ((per_cnt_r < per_len_r) && (per_len_r >= 32'(MIN_PERIOD_MS))))
    else $error("repeat period counter out of range");

endmodule

/* rtl/led_blink_pattern_sequencer.sv */
`timescale 1ns / 1ps

// Channel | Direction | Handshake                   | Payload
// in_     | request   | in_push / in_full           | in_data    (in_item_t)
// out_    | result    | out_pop / out_empty         | out_data   (out_item_t)
// cfg_    | write     | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// The sequencer takes one request per clock while the result queue has room for its result.
// An accepted request is registered in the request queue, and its result is registered
// in the result queue, from which the consumer pops it.
// Reset is synchronous on rst_n; it restores the register defaults and empties every queue.
// A stalled output fills a two-entry result queue and then a two-entry request queue;
// in_full rises only when both are full.

module led_blink_pattern_sequencer import lbps_pkg::*; #(
  parameter int QUEUE_DEPTH   = 8,
  parameter int BURST_PULSES  = 6,
  parameter int MIN_PERIOD_MS = 50
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  in_item_t    in_data,
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SKID_DEPTH = 2;

  // The front end latches configuration, scales burst times and clamps the
  // repeat period, then drops the classified request into a short queue.
  cmd_t                  front_cmd, back_cmd;
  logic                  cmd_push, cmd_full, cmd_empty;
  logic [$bits(cmd_t)-1:0] cmd_rd;
  logic                  active_high;

  // The sequencer retires one request whenever a request waits and the
  // result queue has room.
  logic                  go, res_full;
  out_item_t             back_res;
  logic [$bits(out_item_t)-1:0] res_rd;

  assign go       = !cmd_empty && !res_full;
  assign back_cmd = cmd_t'(cmd_rd);
  assign out_data = out_item_t'(res_rd);

  lbps_front #(
    .MIN_PERIOD_MS (MIN_PERIOD_MS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_data     (in_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd_full    (cmd_full),
    .cmd_push    (cmd_push),
    .cmd         (front_cmd),
    .active_high (active_high)
  );

  lbps_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (SKID_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (front_cmd),
    .full    (cmd_full),
    .pop     (go),
    .rd_data (cmd_rd),
    .empty   (cmd_empty)
  );

  lbps_back #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .BURST_PULSES  (BURST_PULSES),
    .MIN_PERIOD_MS (MIN_PERIOD_MS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (go),
    .cmd         (back_cmd),
    .active_high (active_high),
    .res         (back_res)
  );

  // The result queue decouples the sequencer from a slow consumer.
  lbps_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (SKID_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (go),
    .wr_data (back_res),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (res_rd),
    .empty   (out_empty)
  );

endmodule
